/* hdl/mpd_pkg.sv */
// Shared types and constants for the mean point distance block.
// Used by every module under hdl/; depends on nothing else.
package mpd_pkg;

    // Field widths of the words on the ports
    localparam int COORD_W        = 24;          // signed Q12.12 coordinate
    localparam int DIST_W         = 25;          // unsigned Q13.12 distance
    localparam int POINT_W        = 13;          // point_total field
    localparam int DEF_MAX_POINTS = 4096;        // default saturation count

    // Square root operates on a 2*DIST_W bit radicand, one root bit per step
    localparam int RAD_W       = 2 * DIST_W;
    localparam int QUEUE_DEPTH = 4;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Input word: one reference/estimate point pair
    typedef struct packed {
        coord_t ref_x;
        coord_t ref_y;
        coord_t ref_z;
        coord_t est_x;
        coord_t est_y;
        coord_t est_z;
        logic   last_point;
    } pair_t;

    // Output word: mean over one set of pairs
    typedef struct packed {
        logic [DIST_W-1:0]  mean_distance;
        logic [POINT_W-1:0] point_total;
        logic               count_overflow;
    } result_t;

    // Word passed from the distance front to the accumulator back
    typedef struct packed {
        logic [DIST_W-1:0] pair_dist;
        logic              last;
    } dist_word_t;

endpackage

/* hdl/mpd_front.sv */
// Distance front: accepts a point pair, squares the coordinate differences
// and takes an iterative floor square root. Depends on mpd_pkg.
module mpd_front
    import mpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pair_valid,
    output logic       pair_ready,
    input  pair_t      pair,
    output logic       push_valid,
    input  logic       push_ready,
    output dist_word_t push_word
);

    localparam int SQ_W   = 2 * COORD_W;
    localparam int SSQ_W  = SQ_W + 2;
    localparam int EXT_W  = (SSQ_W > RAD_W + 1) ? SSQ_W : RAD_W + 1;
    localparam int REM_W  = DIST_W + 2;
    localparam int STEP_W = $clog2(DIST_W);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_SQ   = 5'b00010,
        F_SUM  = 5'b00100,
        F_ROOT = 5'b01000,
        F_PUSH = 5'b10000
    } fstate_t;

    fstate_t                    state_reg, state_next;
    logic [2:0][COORD_W-1:0]    mag_reg, mag_next;
    logic [2:0][SQ_W-1:0]       sq_reg, sq_next;
    logic                       last_reg, last_next;
    logic [RAD_W-1:0]           rad_reg, rad_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [DIST_W-1:0]          root_reg, root_next;
    logic [STEP_W-1:0]          step_reg, step_next;

    logic [EXT_W-1:0]           ssq;
    logic [REM_W+1:0]           shifted;
    logic [REM_W+1:0]           trial;

    // |a - b| of two signed coordinates; always fits COORD_W bits
    function automatic logic [COORD_W-1:0] abs_diff(coord_t a, coord_t b);
        logic signed [COORD_W:0] d;
        begin
            d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
            abs_diff = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
        end
    endfunction

    assign pair_ready = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_word  = '{pair_dist: root_reg, last: last_reg};

    // Sum of squares, zero extended so the clamp test works at any width
    assign ssq = EXT_W'(sq_reg[0]) + EXT_W'(sq_reg[1]) + EXT_W'(sq_reg[2]);

    // One root bit per step: bring down two radicand bits, try 4*root+1
    assign shifted = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial   = (REM_W + 2)'({root_reg, 2'b01});

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        sq_next    = sq_reg;
        last_next  = last_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        step_next  = step_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (pair_valid)
                begin
                    mag_next[0] = abs_diff(pair.ref_x, pair.est_x);
                    mag_next[1] = abs_diff(pair.ref_y, pair.est_y);
                    mag_next[2] = abs_diff(pair.ref_z, pair.est_z);
                    last_next   = pair.last_point;
                    state_next  = F_SQ;
                end
            end
            F_SQ:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_next[i] = mag_reg[i] * mag_reg[i];
                end
                state_next = F_SUM;
            end
            F_SUM:
            begin
                rad_next  = ssq[RAD_W-1:0];
                rem_next  = '0;
                step_next = STEP_W'(DIST_W - 1);
                if (|ssq[EXT_W-1:RAD_W])
                begin
                    // distance would exceed the Q13.12 range: clamp
                    root_next  = '1;
                    state_next = F_PUSH;
                end
                else
                begin
                    root_next  = '0;
                    state_next = F_ROOT;
                end
            end
            F_ROOT:
            begin
                rad_next = {rad_reg[RAD_W-3:0], 2'b00};
                if (shifted >= trial)
                begin
                    rem_next  = REM_W'(shifted - trial);
                    root_next = {root_reg[DIST_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = REM_W'(shifted);
                    root_next = {root_reg[DIST_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        sq_reg   <= sq_next;
        last_reg <= last_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        step_reg <= step_next;
    end

endmodule

/* hdl/mpd_queue.sv */
// Short FIFO of distance words between the front and the back.
// Depends on mpd_pkg for the word type.
module mpd_queue
    import mpd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  dist_word_t push_word,
    output logic       pop_valid,
    input  logic       pop_ready,
    output dist_word_t pop_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    dist_word_t         entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     fill_reg, fill_next;
    logic               do_push, do_pop;

    assign push_ready = (fill_reg != (PTR_W + 1)'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_word   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

/* hdl/mpd_back.sv */
// Accumulator back: sums distances, counts pairs, and on the last pair
// runs a bit-serial floor division into the output register. Uses mpd_pkg.
module mpd_back
    import mpd_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  dist_word_t pop_word,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SUM_W  = DIST_W + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [2:0] {
        B_ACC  = 3'b001,
        B_DIV  = 3'b010,
        B_DONE = 3'b100
    } bstate_t;

    bstate_t            state_reg, state_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [DIST_W-1:0]  quot_reg, quot_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic [CNT_W:0]     shifted;
    logic               fits;
    logic               load_out;

    assign pop_ready    = (state_reg == B_ACC);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Restoring division step: bring down the next dividend bit
    assign shifted  = {rem_reg, sum_reg[SUM_W-1]};
    assign fits     = (shifted >= {1'b0, count_reg});
    assign load_out = (state_reg == B_DONE) && (!out_valid_reg || result_ready);

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        step_next      = step_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            B_ACC:
            begin
                if (pop_valid)
                begin
                    // a pair beyond the limit only flags overflow
                    if (count_reg < CNT_W'(MAX_POINTS))
                    begin
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + SUM_W'(pop_word.pair_dist);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (pop_word.last)
                    begin
                        rem_next   = '0;
                        step_next  = STEP_W'(SUM_W - 1);
                        state_next = B_DIV;
                    end
                end
            end
            B_DIV:
            begin
                sum_next  = {sum_reg[SUM_W-2:0], 1'b0};
                rem_next  = fits ? CNT_W'(shifted - {1'b0, count_reg}) : CNT_W'(shifted);
                quot_next = {quot_reg[DIST_W-2:0], fits};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (load_out)
                begin
                    out_next.mean_distance  = quot_reg;
                    out_next.point_total    = POINT_W'(count_reg);
                    out_next.count_overflow = ovf_reg;
                    out_valid_next          = 1'b1;
                    sum_next                = '0;
                    count_next              = '0;
                    ovf_next                = 1'b0;
                    state_next              = B_ACC;
                end
            end
            default:
            begin
                state_next = B_ACC;
            end
        endcase
    end

    // Control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_ACC;
            sum_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Divider and output datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        step_reg <= step_next;
        out_reg  <= out_next;
    end

endmodule

/* hdl/mean_point_distance.sv */
// Top level of the mean point distance block: front, queue and back.
// Depends on mpd_pkg, mpd_front, mpd_queue and mpd_back.
//
// Usage
//   Input channel pair_valid/pair_ready/pair carries one word per point
//   pair (reference and estimate, signed Q12.12). Output channel
//   result_valid/result_ready/result carries one word per set, issued
//   for the pair marked last_point: floor mean distance (Q13.12), the
//   pair count (saturated at MAX_POINTS) and an overflow flag.
//   The front works on one pair at a time and takes no new pair until
//   it has pushed that pair's distance; its pace is set by the
//   bit-serial square root (one root bit per cycle, 25 bits), which a
//   pair whose distance clamps skips. A last pair passes the front's
//   square, sum and root states, the queue, the back's bit-serial
//   division and the load into the output register, in that order.
//   A 4-word queue lets the front keep accepting pairs while the back
//   divides. If the receiver stalls, the result holds in the output
//   register; the back then waits, the queue fills and pair_ready drops.
//   Reset (rst_n low, asynchronous) empties the queue and clears the
//   sum, the count and the overflow flag.
module mean_point_distance
    import mpd_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pair_valid,
    output logic    pair_ready,
    input  pair_t   pair,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic       push_valid, push_ready;
    dist_word_t push_word;
    logic       pop_valid, pop_ready;
    dist_word_t pop_word;

    // Per-pair distance
    mpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair       (pair),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    // Decoupling queue
    mpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    // Accumulate and average
    mpd_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_word     (pop_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* hdl/mpd_checker.sv */
// Port-level checks for mean_point_distance, attached by bind.
// Depends on mpd_pkg.
module mpd_checker
    import mpd_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    pair_valid,
    input logic    pair_ready,
    input pair_t   pair,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // Offered pair word holds until taken
    a_pair_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && !pair_ready |=> pair_valid && $stable(pair))
        else $error("pair word changed while waiting");

    // Stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // Front works on one pair at a time
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && pair_ready |=> !pair_ready)
        else $error("pair accepted while front busy");

    // Overflow only with a full count
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.count_overflow |->
            result.point_total == POINT_W'(MAX_POINTS))
        else $error("overflow flagged without full count");

endmodule

bind mean_point_distance mpd_checker #(.MAX_POINTS(MAX_POINTS)) u_mpd_checker (.*);
